[sv/sipq_pkg.sv]
// ----------------------------------------------------------------------------
// sipq_pkg
// Shared types and constants for the sorted-insert priority queue: status and
// kind codes, controller states, and the command/status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sipq_pkg;

    // Default sizing
    localparam int CAPACITY_DEF     = 64;
    localparam int PAYLOAD_BITS_DEF = 16;

    // Fixed field widths
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;

    // Item kind codes
    typedef enum logic
    {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } kind_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0]
    {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [3:0]
    {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INSERT,
        S_POP_RD,
        S_POP_DATA,
        S_FINISH
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed
    {
        logic    accept;      // latch the incoming transaction
        logic    res_init;    // set result status, clear popped entry
        status_t res_status;  // status code for res_init
        logic    rd_en;       // read the entry at logical index idx
        logic    scan_step;   // compare read entry, advance scan
        logic    shift_wr;    // move read entry one place towards the tail
        logic    insert;      // write the new entry at the insert position
        logic    pop;         // capture head entry and retire it
        logic    finish;      // load the output register
    } sipq_cmd_t;

    // Status from datapath to controller
    typedef struct packed
    {
        logic kind_deq;    // latched transaction is a dequeue
        logic full;        // queue holds CAPACITY entries
        logic empty;       // queue holds no entry
        logic ahead;       // new key goes in front of the read entry
        logic scan_last;   // scan has reached the last stored entry
        logic shift_last;  // shift has reached the insert position
        logic out_busy;    // output register holds a result not yet taken
    } sipq_stat_t;

endpackage

`default_nettype wire

[sv/sorted_insert_priority_queue_core.sv]
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_core
// Priority queue kept as a sorted list in one memory; enqueue inserts in
// order, dequeue returns the head entry.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (in_valid/in_stall) carries kind, priority_req, payload.
//   Each transaction yields one result on the output channel
//   (out_valid/out_stall): status, out_priority, out_payload, entry_count.
//   cfg_wr_en/cfg_wr_data write the order bit (0 smallest first, 1 largest
//   first); write it only while the block is idle.
// Steps: a dequeue reads the head entry and retires it; a dequeue on empty
//   or an enqueue on full only sets the status. An enqueue compares from
//   the head until the new key goes ahead of an entry, moves that entry and
//   those behind it one place back, then writes the new entry. A compare
//   is a read and a compare step, a move a read and a write step (one
//   registered read port). The result is loaded as the block returns to idle.
// Reset: queue empty, order ascending, no result pending; no clearing pass.
// Stall: a result waits in the output register; the next transaction is
//   accepted and worked on, and holds in its last step until the register
//   is free.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_insert_priority_queue_core
    import sipq_pkg::*;
#(
    parameter int CAPACITY     = CAPACITY_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
    parameter int CNT_W        = $clog2(CAPACITY + 1)
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_wr_en,
    input  wire logic                    cfg_wr_data,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    kind,
    input  wire logic signed [KEY_W-1:0] priority_req,
    input  wire logic [PAYLOAD_BITS-1:0] payload,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [STATUS_W-1:0]          status,
    output logic signed [KEY_W-1:0]      out_priority,
    output logic [PAYLOAD_BITS-1:0]      out_payload,
    output logic [CNT_W-1:0]             entry_count
);

    sipq_cmd_t  cmd;
    sipq_stat_t stat;

    // Sequencer
    sipq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage, compare and output register
    sipq_dpath #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .CNT_W        (CNT_W)
    ) u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .kind         (kind),
        .priority_req (priority_req),
        .payload      (payload),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .out_priority (out_priority),
        .out_payload  (out_payload),
        .entry_count  (entry_count),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

`default_nettype wire

[sv/sipq_ctrl.sv]
// ----------------------------------------------------------------------------
// sipq_ctrl
// Controller state machine: sequences the scan, shift, insert and pop steps
// of one transaction and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sipq_ctrl
    import sipq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire sipq_stat_t stat,
    output sipq_cmd_t       cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.kind_deq)
                begin
                    state_next = stat.empty ? S_FINISH : S_POP_RD;
                end
                else if (stat.full)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = stat.empty ? S_INSERT : S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (stat.ahead)
                begin
                    state_next = S_SHIFT_RD;
                end
                else if (stat.scan_last)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                state_next = stat.shift_last ? S_INSERT : S_SHIFT_RD;
            end
            S_INSERT:
            begin
                state_next = S_FINISH;
            end
            S_POP_RD:
            begin
                state_next = S_POP_DATA;
            end
            S_POP_DATA:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd            = '0;
        cmd.res_status = ST_DONE;
        in_stall       = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            S_DECODE:
            begin
                cmd.res_init = 1'b1;
                if (stat.kind_deq && stat.empty)
                begin
                    cmd.res_status = ST_EMPTY;
                end
                else if (!stat.kind_deq && stat.full)
                begin
                    cmd.res_status = ST_FULL;
                end
            end
            S_SCAN_RD, S_SHIFT_RD, S_POP_RD:
            begin
                cmd.rd_en = 1'b1;
            end
            S_SCAN_CMP:
            begin
                cmd.scan_step = 1'b1;
            end
            S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
            end
            S_POP_DATA:
            begin
                cmd.pop = 1'b1;
            end
            S_FINISH:
            begin
                cmd.finish = !stat.out_busy;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/sipq_dpath.sv]
// ----------------------------------------------------------------------------
// sipq_dpath
// Datapath: entry memory kept as a circular buffer in sorted order, head
// pointer, entry count, scan/shift indices, key compare, order register and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sipq_dpath
    import sipq_pkg::*;
#(
    parameter int CAPACITY     = CAPACITY_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
    parameter int CNT_W        = $clog2(CAPACITY + 1)
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // configuration
    input  wire logic                    cfg_wr_en,
    input  wire logic                    cfg_wr_data,
    // input transaction
    input  wire logic                    kind,
    input  wire logic signed [KEY_W-1:0] priority_req,
    input  wire logic [PAYLOAD_BITS-1:0] payload,
    // result transaction
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [STATUS_W-1:0]          status,
    output logic signed [KEY_W-1:0]      out_priority,
    output logic [PAYLOAD_BITS-1:0]      out_payload,
    output logic [CNT_W-1:0]             entry_count,
    // control
    input  wire sipq_cmd_t               cmd,
    output sipq_stat_t                   stat
);

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int SUM_W   = CNT_W + 1;
    localparam int ENTRY_W = KEY_W + PAYLOAD_BITS;

    // Entry memory and registered read data
    logic [ENTRY_W-1:0]      mem [CAPACITY];
    logic [ENTRY_W-1:0]      rd_data_reg;

    // Control registers
    logic                    descending_reg;
    logic [ADDR_W-1:0]       head_reg;
    logic [ADDR_W-1:0]       head_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic [CNT_W-1:0]        pos_reg;
    logic                    out_valid_reg;

    // Transaction and result registers
    logic                    kind_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [PAYLOAD_BITS-1:0] tag_reg;
    status_t                 res_status_reg;
    logic signed [KEY_W-1:0] res_key_reg;
    logic [PAYLOAD_BITS-1:0] res_tag_reg;
    logic [STATUS_W-1:0]     status_reg;
    logic signed [KEY_W-1:0] out_priority_reg;
    logic [PAYLOAD_BITS-1:0] out_payload_reg;
    logic [CNT_W-1:0]        entry_count_reg;

    // Address generation and compare
    logic [CNT_W-1:0]        idx_inc;
    logic [CNT_W-1:0]        wr_off;
    logic [SUM_W-1:0]        rd_sum;
    logic [SUM_W-1:0]        wr_sum;
    logic [SUM_W-1:0]        rd_phys;
    logic [SUM_W-1:0]        wr_phys;
    logic [ADDR_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       wr_addr;
    logic                    wr_en;
    logic [ENTRY_W-1:0]      wr_data;
    logic signed [KEY_W-1:0] rd_key;
    logic [PAYLOAD_BITS-1:0] rd_tag;
    logic                    ahead;

    // Map logical offsets from the head onto memory addresses
    always_comb
    begin
        idx_inc = idx_reg + CNT_W'(1);
        wr_off  = cmd.insert ? pos_reg : idx_inc;
        rd_sum  = SUM_W'(head_reg) + SUM_W'(idx_reg);
        wr_sum  = SUM_W'(head_reg) + SUM_W'(wr_off);
        rd_phys = (rd_sum >= SUM_W'(CAPACITY)) ? rd_sum - SUM_W'(CAPACITY) : rd_sum;
        wr_phys = (wr_sum >= SUM_W'(CAPACITY)) ? wr_sum - SUM_W'(CAPACITY) : wr_sum;
        rd_addr = rd_phys[ADDR_W-1:0];
        wr_addr = wr_phys[ADDR_W-1:0];
        wr_en   = cmd.shift_wr | cmd.insert;
        wr_data = cmd.insert ? {key_reg, tag_reg} : rd_data_reg;
    end

    // Split read entry and compare against the new key
    always_comb
    begin
        rd_key = rd_data_reg[ENTRY_W-1 -: KEY_W];
        rd_tag = rd_data_reg[PAYLOAD_BITS-1:0];
        ahead  = descending_reg ? (key_reg >= rd_key) : (key_reg <= rd_key);
    end

    // Advance head with wrap
    always_comb
    begin
        if (head_reg == ADDR_W'(CAPACITY - 1))
        begin
            head_next = '0;
        end
        else
        begin
            head_next = head_reg + ADDR_W'(1);
        end
    end

    // Entry memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            descending_reg <= 1'b0;
            head_reg       <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                descending_reg <= cfg_wr_data;
            end
            // start each transaction at the head
            if (cmd.accept)
            begin
                idx_reg <= '0;
                pos_reg <= '0;
            end
            // scan: stop at the first entry the new key goes before
            if (cmd.scan_step)
            begin
                pos_reg <= ahead ? idx_reg : idx_inc;
                idx_reg <= ahead ? (count_reg - CNT_W'(1)) : idx_inc;
            end
            // shift: walk back from the tail
            if (cmd.shift_wr)
            begin
                idx_reg <= idx_reg - CNT_W'(1);
            end
            if (cmd.insert)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.pop)
            begin
                head_reg  <= head_next;
                count_reg <= count_reg - CNT_W'(1);
            end
            // output valid: set on load, drop when taken
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Transaction, result and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg <= kind;
            key_reg  <= priority_req;
            tag_reg  <= payload;
        end
        if (cmd.res_init)
        begin
            res_status_reg <= cmd.res_status;
            res_key_reg    <= '0;
            res_tag_reg    <= '0;
        end
        if (cmd.pop)
        begin
            res_key_reg <= rd_key;
            res_tag_reg <= rd_tag;
        end
        if (cmd.finish)
        begin
            status_reg       <= res_status_reg;
            out_priority_reg <= res_key_reg;
            out_payload_reg  <= res_tag_reg;
            entry_count_reg  <= count_reg;
        end
    end

    // Status towards the controller
    always_comb
    begin
        stat.kind_deq   = (kind_reg == KIND_DEQ);
        stat.full       = (count_reg == CNT_W'(CAPACITY));
        stat.empty      = (count_reg == '0);
        stat.ahead      = ahead;
        stat.scan_last  = (idx_inc == count_reg);
        stat.shift_last = (idx_reg == pos_reg);
        stat.out_busy   = out_valid_reg & out_stall;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_priority = out_priority_reg;
    assign out_payload  = out_payload_reg;
    assign entry_count  = entry_count_reg;

endmodule

`default_nettype wire

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_insert_priority_queue_core. A directed
// opening covers the key extremes, ties, both orders and the empty queue.
// Random phases then fill the queue past capacity, drain it past empty and
// mix both operations. The order bit is flipped between phases while entries
// are still held. A scoreboard keeps its own sorted copy of the queue and
// checks every result, field by field and in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import sipq_pkg::*;

    localparam int CAP       = CAPACITY_DEF;
    localparam int PAY_W     = PAYLOAD_BITS_DEF;
    localparam int CNT_W     = $clog2(CAP + 1);
    localparam int LIMIT     = 600000;
    localparam int TAIL_WAIT = 20;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [PAY_W-1:0]        tag_t;

    typedef struct packed
    {
        status_t          st;
        key_t             key;
        tag_t             tag;
        logic [CNT_W-1:0] cnt;
    } pq_result_t;

    typedef enum int
    {
        MIX_OPS,
        FILL_UP,
        DRAIN_OUT
    } phase_mode_t;

    // ------------------------------------------------------------------------
    // Scoreboard: sorted copy of the queue and results still owed
    // ------------------------------------------------------------------------
    class sorted_queue_model;
        bit         order_desc;
        key_t       held_keys[$];
        tag_t       held_tags[$];
        pq_result_t owed[$];
        int         errors;
        int         n_items;
        int         n_deq;
        int         n_empty;
        int         n_full;
        int         n_checked;
        int         peak;

        function new();
            order_desc = 1'b0;
            errors     = 0;
            n_items    = 0;
            n_deq      = 0;
            n_empty    = 0;
            n_full     = 0;
            n_checked  = 0;
            peak       = 0;
        endfunction

        task report(string what);
            errors++;
            $display("ERROR: %s", what);
        endtask

        // true if a fresh key sits in front of a held key under the order
        function bit goes_ahead(key_t fresh, key_t held);
            if (order_desc)
                return fresh >= held;
            return fresh <= held;
        endfunction

        // work out the result of one accepted transaction
        function void take_item(kind_t k, key_t key, tag_t tag);
            pq_result_t r;
            int         pos;
            r.st  = ST_DONE;
            r.key = '0;
            r.tag = '0;
            n_items++;
            if (k == KIND_ENQ)
            begin
                if (held_keys.size() >= CAP)
                begin
                    r.st = ST_FULL;
                    n_full++;
                end
                else
                begin
                    pos = 0;
                    while (pos < held_keys.size() && !goes_ahead(key, held_keys[pos]))
                        pos++;
                    if (pos == held_keys.size())
                    begin
                        held_keys.push_back(key);
                        held_tags.push_back(tag);
                    end
                    else
                    begin
                        held_keys.insert(pos, key);
                        held_tags.insert(pos, tag);
                    end
                end
            end
            else
            begin
                n_deq++;
                if (held_keys.size() == 0)
                begin
                    r.st = ST_EMPTY;
                    n_empty++;
                end
                else
                begin
                    r.key = held_keys.pop_front();
                    r.tag = held_tags.pop_front();
                end
            end
            r.cnt = CNT_W'(held_keys.size());
            if (held_keys.size() > peak)
                peak = held_keys.size();
            owed.push_back(r);
        endfunction

        // compare one result with the oldest one owed
        task check_result(logic [STATUS_W-1:0] st, key_t key, tag_t tag,
                          logic [CNT_W-1:0] cnt);
            pq_result_t r;
            if (owed.size() == 0)
            begin
                report("result arrived with nothing outstanding");
                return;
            end
            r = owed.pop_front();
            n_checked++;
            if (st !== r.st)
                report($sformatf("result %0d: status %0d, want %0d",
                                 n_checked, st, r.st));
            if (key !== r.key)
                report($sformatf("result %0d: out_priority %0d, want %0d",
                                 n_checked, key, r.key));
            if (tag !== r.tag)
                report($sformatf("result %0d: out_payload 0x%h, want 0x%h",
                                 n_checked, tag, r.tag));
            if (cnt !== r.cnt)
                report($sformatf("result %0d: entry_count %0d, want %0d",
                                 n_checked, cnt, r.cnt));
        endtask

        function int pending();
            return owed.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block
    // ------------------------------------------------------------------------
    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic                cfg_wr_data;
    logic                in_valid;
    logic                in_stall;
    logic                kind;
    key_t                priority_req;
    tag_t                payload;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    key_t                out_priority;
    tag_t                out_payload;
    logic [CNT_W-1:0]    entry_count;

    sorted_queue_model   model;
    int                  cycles;
    int                  order_writes;
    int                  burst_left;

    sorted_insert_priority_queue_core
    #(
        .CAPACITY     (CAP),
        .PAYLOAD_BITS (PAY_W)
    )
    dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .priority_req (priority_req),
        .payload      (payload),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .out_priority (out_priority),
        .out_payload  (out_payload),
        .entry_count  (entry_count)
    );

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Cycle counter with run limit (int starts at zero)
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Note every accepted input transaction
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            model.take_item(kind_t'(kind), priority_req, payload);
    end

    // Check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            model.check_result(status, out_priority, out_payload, entry_count);
    end

    // Receiver stall pattern in one of four randomly chosen modes
    int stall_mode;
    int stall_tick;
    always @(negedge clk)
    begin
        if (stall_tick % 48 == 0)
            stall_mode = $urandom_range(0, 3);
        stall_tick++;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((stall_tick % 11) < 7);
        endcase
    end

    // ------------------------------------------------------------------------
    // Driving tasks (all entered and left at a falling edge)
    // ------------------------------------------------------------------------

    // Offer one transaction and hold it until accepted
    task send_item(kind_t k, key_t key, tag_t tag);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid     <= 1'b1;
        kind         <= k;
        priority_req <= key;
        payload      <= tag;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold off until every owed result has come back
    task wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (model.pending() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write the order bit while the block is idle
    task write_order(bit desc);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= desc;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        model.order_desc = desc;
        order_writes++;
        @(negedge clk);
    endtask

    function key_t pick_key();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3:    return key_t'($urandom_range(0, 6)) - 3;
            default: return key_t'($urandom);
        endcase
    endfunction

    // Random phase: enqueue share set by the mode
    task run_phase(phase_mode_t mode, int n);
        int enq_pct;
        case (mode)
            FILL_UP:   enq_pct = 88;
            DRAIN_OUT: enq_pct = 12;
            default:   enq_pct = 50;
        endcase
        repeat (n)
        begin
            if ($urandom_range(0, 99) < enq_pct)
                send_item(KIND_ENQ, pick_key(), tag_t'($urandom));
            else
                send_item(KIND_DEQ, key_t'($urandom), tag_t'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        model        = new();
        order_writes = 0;
        burst_left   = 0;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = 1'b0;
        in_valid     = 1'b0;
        kind         = KIND_ENQ;
        priority_req = '0;
        payload      = '0;

        // hold reset low, then release it
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: ascending order, extremes, ties, empty queue
        write_order(1'b0);
        send_item(KIND_DEQ, 32'sh7fff_ffff, 16'hffff);
        send_item(KIND_ENQ, 32'sd0,         16'h0000);
        send_item(KIND_ENQ, 32'sh7fff_ffff, 16'hffff);
        send_item(KIND_ENQ, 32'sh8000_0000, 16'h1234);
        send_item(KIND_ENQ, 32'sd0,         16'haaaa);
        send_item(KIND_ENQ, -32'sd1,        16'h5555);
        repeat (4) send_item(KIND_DEQ, '0, '0);

        // directed: descending order with an entry still held
        write_order(1'b1);
        send_item(KIND_ENQ, 32'sd5,         16'h00ff);
        send_item(KIND_ENQ, 32'sh7fff_ffff, 16'hff00);
        send_item(KIND_ENQ, 32'sh8000_0000, 16'h8001);
        send_item(KIND_ENQ, 32'sd5,         16'h7ffe);
        repeat (6) send_item(KIND_DEQ, '0, '0);

        // random phases, order flipped with entries held
        write_order(1'b1);
        run_phase(FILL_UP, 90);
        write_order(1'b0);
        run_phase(MIX_OPS, 50);
        run_phase(FILL_UP, 50);
        write_order(1'b1);
        run_phase(MIX_OPS, 40);
        run_phase(DRAIN_OUT, 90);
        write_order(1'b0);
        run_phase(FILL_UP, 80);
        write_order(1'b1);
        run_phase(DRAIN_OUT, 50);

        // drain remaining results and let the block settle
        wait_idle();
        repeat (TAIL_WAIT) @(negedge clk);

        $display("Ran %0d transactions: %0d dequeues, %0d on an empty queue, %0d %s",
                 model.n_items, model.n_deq, model.n_empty, model.n_full,
                 "dropped as full.");
        $display("Checked %0d results, peak occupancy %0d, order bit written %0d times.",
                 model.n_checked, model.peak, order_writes);
        if (model.errors == 0 && model.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

[sorted_insert_priority_queue_core.f]
sv/sipq_pkg.sv
sv/sipq_ctrl.sv
sv/sipq_dpath.sv
sv/sorted_insert_priority_queue_core.sv
dv/testbench.sv
